/* src/uww_pkg.sv */
// Shared constants for the UTF-8 word wrapper.
// No dependencies; imported by utf8_word_wrapper.
package uww_pkg;

    localparam int unsigned MAX_CELLS_DEF = 60;
    localparam int unsigned RESULT_LIMIT  = 34;
    localparam int unsigned CNT_W         = 6;
    localparam int unsigned CFG_W         = 6;
    localparam int unsigned CP_W          = 21;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic [CP_W-1:0] CP_TAB      = 21'h00_0009;
    localparam logic [CP_W-1:0] CP_LF       = 21'h00_000A;
    localparam logic [CP_W-1:0] CP_CR       = 21'h00_000D;
    localparam logic [CP_W-1:0] CP_SPACE    = 21'h00_0020;
    localparam logic [CP_W-1:0] CP_ASCII    = 21'h00_007F;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10_FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00_D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00_DFFF;
    localparam logic [CP_W-1:0] MIN_TWO     = 21'h00_0080;
    localparam logic [CP_W-1:0] MIN_THREE   = 21'h00_0800;
    localparam logic [CP_W-1:0] MIN_FOUR    = 21'h01_0000;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

endpackage

/* src/utf8_word_wrapper.sv */
// UTF-8 decoder and greedy word wrapper, top level.
// Depends on uww_pkg; holds the word buffer memory and the control sequencer.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, kind, text_byte            | sink
//  out     | out_valid, out_ready, code_point, line_end,    | source
//          | decode_error, last                             |
//  cfg     | cfg_valid, cfg_ready, max_cells                | sink
//
// An input beat may only advance the decoder, drop a carriage return, report an
// error, land in the word buffer, or flush the word for a separator, line feed,
// end of text or a word that no longer fits. A word flush reads the buffered code
// points in turn through the single read port of the word buffer, with a line end
// ahead of a point that opens a new line. Results pass through a staging register
// and the output register, so a stalled out channel stalls the sequencer only
// when both are full. At most 34 results close one input beat; any overflow is
// held and resumes ahead of the next beat's work.
// Reset clears all control state; the word buffer needs no clearing.
module utf8_word_wrapper #(
    parameter int unsigned MAX_CELLS = uww_pkg::MAX_CELLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [7:0]                  text_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [uww_pkg::CP_W-1:0]    code_point,
    output logic                        line_end,
    output logic                        decode_error,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [uww_pkg::CFG_W-1:0]   max_cells
);
    import uww_pkg::*;

    localparam int unsigned IW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned LW  = $clog2(MAX_CELLS + 1);
    localparam int unsigned LCW = $clog2(4 * MAX_CELLS + 4);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_ACT, S_ERR, S_ERR_END, S_F_START, S_F_SPACE, S_F_RD,
        S_F_PT, S_STORE, S_LF_END, S_SP_SET, S_END_FIN, S_DONE
    } state_t;

    typedef enum logic [1:0] {R_STORE, R_LF, R_SP, R_END} ret_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            le;
        logic            err;
    } res_t;

    state_t state_reg;
    ret_t   ret_reg;

    // Configuration
    logic [CFG_W-1:0] max_cells_reg;

    // Input latch and the beat held while overflow results drain
    logic       kind_reg, pend_kind_reg, pend_reg;
    logic [7:0] byte_reg, pend_byte_reg;

    // Decoder
    logic [CP_W-1:0] part_reg;
    logic [1:0]      left_reg;
    logic [2:0]      seq_reg;
    logic [CP_W-1:0] cp_reg;

    // Wrapper
    logic [LW-1:0]  word_len_reg;
    logic [LCW-1:0] word_cells_reg, line_cells_reg;
    logic           space_reg, error_reg;
    logic [IW-1:0]  idx_reg;

    // Result path
    res_t             stg_reg;
    logic             stg_valid_reg, paused_reg;
    logic [CNT_W-1:0] cnt_reg;
    res_t             out_reg;
    logic             out_valid_reg, out_last_reg;

    // Word buffer
    logic [CP_W-1:0] word_mem [MAX_CELLS];
    logic [CP_W-1:0] rd_data_reg;
    logic            rd_en, wr_en;

    logic [LCW-1:0]  lim;
    logic [CP_W-1:0] next_part, cp_new;
    logic            seq_bad;
    logic [LCW-1:0]  w_cp, w_rd, sp_add;
    logic            want_emit, emit_done, out_free, out_load, brk_pt, idx_end;
    res_t            emit_res;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE) || (paused_reg && !pend_reg);
    assign out_valid    = out_valid_reg;
    assign code_point   = out_reg.cp;
    assign line_end     = out_reg.le;
    assign decode_error = out_reg.err;
    assign last         = out_last_reg;
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        if (max_cells_reg == '0)
            lim = LCW'(1);
        else if (LCW'(max_cells_reg) > LCW'(MAX_CELLS))
            lim = LCW'(MAX_CELLS);
        else
            lim = LCW'(max_cells_reg);
    end

    assign next_part = {part_reg[CP_W-7:0], byte_reg[5:0]};
    assign cp_new    = (left_reg == 2'd0) ? {{(CP_W-8){1'b0}}, byte_reg} : next_part;
    assign seq_bad   = ((seq_reg == 3'd2) && (next_part < MIN_TWO))
                    || ((seq_reg == 3'd3) && (next_part < MIN_THREE))
                    || ((seq_reg == 3'd4) && (next_part < MIN_FOUR))
                    || (next_part > CP_MAX)
                    || ((next_part >= CP_SURR_LO) && (next_part <= CP_SURR_HI));
    assign w_cp      = (cp_reg <= CP_ASCII) ? LCW'(1) : LCW'(2);
    assign w_rd      = (rd_data_reg <= CP_ASCII) ? LCW'(1) : LCW'(2);
    assign sp_add    = (space_reg && line_cells_reg != '0) ? LCW'(1) : LCW'(0);
    assign brk_pt    = (line_cells_reg != '0) && (line_cells_reg + w_rd > lim);
    assign idx_end   = (LW'(idx_reg) + LW'(1)) >= word_len_reg;

    // Pick the result this state wants to send
    always_comb
    begin
        want_emit = 1'b0;
        emit_res  = '{cp: '0, le: 1'b0, err: 1'b0};
        case (state_reg)
            S_ERR:
            begin
                want_emit = 1'b1;
                emit_res  = '{cp: '0, le: 1'b0, err: 1'b1};
            end
            S_ERR_END:
            begin
                want_emit = 1'b1;
                emit_res  = '{cp: '0, le: 1'b1, err: 1'b1};
            end
            S_LF_END, S_END_FIN:
            begin
                want_emit = 1'b1;
                emit_res  = '{cp: '0, le: 1'b1, err: 1'b0};
            end
            S_F_START:
            begin
                want_emit = (word_len_reg != '0) && (line_cells_reg != '0)
                         && (line_cells_reg + sp_add + word_cells_reg > lim);
                emit_res  = '{cp: '0, le: 1'b1, err: 1'b0};
            end
            S_F_SPACE:
            begin
                want_emit = space_reg && (line_cells_reg != '0);
                emit_res  = '{cp: CP_SPACE, le: 1'b0, err: 1'b0};
            end
            S_F_PT:
            begin
                want_emit = 1'b1;
                emit_res  = brk_pt ? res_t'{cp: '0, le: 1'b1, err: 1'b0}
                                   : res_t'{cp: rd_data_reg, le: 1'b0, err: 1'b0};
            end
            default:
            begin
                want_emit = 1'b0;
            end
        endcase
    end

    assign emit_done = want_emit && !paused_reg
                    && (!stg_valid_reg || (out_free && cnt_reg != CNT_W'(RESULT_LIMIT - 1)));
    // The output register takes the staged result in this cycle
    assign out_load  = out_free && stg_valid_reg
                    && ((want_emit && !paused_reg) || (state_reg == S_DONE && !pend_reg));
    assign rd_en     = (state_reg == S_F_RD);
    assign wr_en     = (state_reg == S_STORE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            word_mem[word_len_reg[IW-1:0]] <= cp_reg;
        if (rd_en)
            rd_data_reg <= word_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= R_STORE;
            max_cells_reg  <= CFG_RESET;
            pend_reg       <= 1'b0;
            part_reg       <= '0;
            left_reg       <= '0;
            seq_reg        <= '0;
            word_len_reg   <= '0;
            word_cells_reg <= '0;
            line_cells_reg <= '0;
            space_reg      <= 1'b0;
            error_reg      <= 1'b0;
            idx_reg        <= '0;
            stg_valid_reg  <= 1'b0;
            paused_reg     <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_cells_reg <= max_cells;

            if (out_ready && !out_load)
                out_valid_reg <= 1'b0;

            // Staging: move the held result out, or pause at the result limit
            if (want_emit && !paused_reg)
            begin
                if (!stg_valid_reg)
                begin
                    stg_reg       <= emit_res;
                    stg_valid_reg <= 1'b1;
                end
                else if (out_free)
                begin
                    out_reg       <= stg_reg;
                    out_valid_reg <= 1'b1;
                    if (cnt_reg == CNT_W'(RESULT_LIMIT - 1))
                    begin
                        out_last_reg  <= 1'b1;
                        stg_valid_reg <= 1'b0;
                        paused_reg    <= 1'b1;
                        cnt_reg       <= '0;
                    end
                    else
                    begin
                        out_last_reg <= 1'b0;
                        cnt_reg      <= cnt_reg + CNT_W'(1);
                        stg_reg      <= emit_res;
                    end
                end
            end

            // Hold the next beat while overflow results drain
            if (paused_reg && !pend_reg && in_valid)
            begin
                pend_reg      <= 1'b1;
                pend_kind_reg <= kind;
                pend_byte_reg <= text_byte;
                paused_reg    <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        byte_reg  <= text_byte;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    if (kind_reg == KIND_END)
                    begin
                        if (error_reg || left_reg != 2'd0)
                            state_reg <= S_ERR_END;
                        else
                        begin
                            ret_reg   <= R_END;
                            state_reg <= S_F_START;
                        end
                    end
                    else if (error_reg)
                        state_reg <= S_DONE;
                    else if (left_reg == 2'd0)
                    begin
                        if (byte_reg[7] == 1'b0)
                        begin
                            cp_reg    <= cp_new;
                            state_reg <= S_ACT;
                        end
                        else if (byte_reg[7:5] == 3'b110)
                        begin
                            part_reg  <= {{(CP_W-5){1'b0}}, byte_reg[4:0]};
                            seq_reg   <= 3'd2;
                            left_reg  <= 2'd1;
                            state_reg <= S_DONE;
                        end
                        else if (byte_reg[7:4] == 4'b1110)
                        begin
                            part_reg  <= {{(CP_W-4){1'b0}}, byte_reg[3:0]};
                            seq_reg   <= 3'd3;
                            left_reg  <= 2'd2;
                            state_reg <= S_DONE;
                        end
                        else if (byte_reg[7:3] == 5'b11110)
                        begin
                            part_reg  <= {{(CP_W-3){1'b0}}, byte_reg[2:0]};
                            seq_reg   <= 3'd4;
                            left_reg  <= 2'd3;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            error_reg <= 1'b1;
                            state_reg <= S_ERR;
                        end
                    end
                    else if (byte_reg[7:6] != 2'b10)
                    begin
                        error_reg <= 1'b1;
                        part_reg  <= '0;
                        left_reg  <= '0;
                        seq_reg   <= '0;
                        state_reg <= S_ERR;
                    end
                    else if (left_reg == 2'd1)
                    begin
                        part_reg <= '0;
                        left_reg <= '0;
                        seq_reg  <= '0;
                        if (seq_bad)
                        begin
                            error_reg <= 1'b1;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            cp_reg    <= cp_new;
                            state_reg <= S_ACT;
                        end
                    end
                    else
                    begin
                        part_reg  <= next_part;
                        left_reg  <= left_reg - 2'd1;
                        state_reg <= S_DONE;
                    end
                end
                S_ACT:
                begin
                    if (cp_reg == CP_CR)
                        state_reg <= S_DONE;
                    else if (cp_reg == CP_LF)
                    begin
                        ret_reg   <= R_LF;
                        state_reg <= S_F_START;
                    end
                    else if (cp_reg == CP_SPACE || cp_reg == CP_TAB)
                    begin
                        ret_reg   <= R_SP;
                        state_reg <= S_F_START;
                    end
                    else if (word_len_reg != '0
                             && (word_cells_reg + w_cp > lim
                                 || word_len_reg >= LW'(MAX_CELLS)))
                    begin
                        ret_reg   <= R_STORE;
                        state_reg <= S_F_START;
                    end
                    else
                        state_reg <= S_STORE;
                end
                S_ERR:
                begin
                    if (emit_done)
                        state_reg <= S_DONE;
                end
                S_ERR_END, S_END_FIN:
                begin
                    if (emit_done)
                    begin
                        part_reg       <= '0;
                        left_reg       <= '0;
                        seq_reg        <= '0;
                        word_len_reg   <= '0;
                        word_cells_reg <= '0;
                        line_cells_reg <= '0;
                        space_reg      <= 1'b0;
                        error_reg      <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                end
                S_F_START:
                begin
                    if (word_len_reg == '0)
                    begin
                        case (ret_reg)
                            R_STORE: state_reg <= S_STORE;
                            R_LF:    state_reg <= S_LF_END;
                            R_SP:    state_reg <= S_SP_SET;
                            default: state_reg <= S_END_FIN;
                        endcase
                    end
                    else if (!want_emit)
                        state_reg <= S_F_SPACE;
                    else if (emit_done)
                    begin
                        line_cells_reg <= '0;
                        state_reg      <= S_F_SPACE;
                    end
                end
                S_F_SPACE:
                begin
                    idx_reg <= '0;
                    if (!want_emit)
                        state_reg <= S_F_RD;
                    else if (emit_done)
                    begin
                        line_cells_reg <= line_cells_reg + LCW'(1);
                        state_reg      <= S_F_RD;
                    end
                end
                S_F_RD:
                begin
                    state_reg <= S_F_PT;
                end
                S_F_PT:
                begin
                    if (emit_done)
                    begin
                        if (brk_pt)
                            line_cells_reg <= '0;
                        else
                        begin
                            line_cells_reg <= line_cells_reg + w_rd;
                            if (idx_end)
                            begin
                                word_len_reg   <= '0;
                                word_cells_reg <= '0;
                                space_reg      <= 1'b0;
                                case (ret_reg)
                                    R_STORE: state_reg <= S_STORE;
                                    R_LF:    state_reg <= S_LF_END;
                                    R_SP:    state_reg <= S_SP_SET;
                                    default: state_reg <= S_END_FIN;
                                endcase
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + IW'(1);
                                state_reg <= S_F_RD;
                            end
                        end
                    end
                end
                S_STORE:
                begin
                    word_len_reg   <= word_len_reg + LW'(1);
                    word_cells_reg <= word_cells_reg + w_cp;
                    state_reg      <= S_DONE;
                end
                S_LF_END:
                begin
                    if (emit_done)
                    begin
                        line_cells_reg <= '0;
                        space_reg      <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                end
                S_SP_SET:
                begin
                    space_reg <= (line_cells_reg != '0);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (pend_reg)
                    begin
                        kind_reg  <= pend_kind_reg;
                        byte_reg  <= pend_byte_reg;
                        pend_reg  <= 1'b0;
                        state_reg <= S_DEC;
                    end
                    else if (!stg_valid_reg)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        // Close the beat: the held result is its last
                        out_reg       <= stg_reg;
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= 1'b1;
                        stg_valid_reg <= 1'b0;
                        cnt_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A pause always hands the staged result out first
    assert property (@(posedge clk) disable iff (!rst_n) paused_reg |-> !stg_valid_reg)
        else $error("staged result held across a pause");

    // Nothing stays staged once the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stg_valid_reg)
        else $error("staged result left behind at idle");

    // The per-beat result count never reaches the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(RESULT_LIMIT))
        else $error("result count out of range");

    // The word buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= LW'(MAX_CELLS))
        else $error("word buffer overflow");

endmodule
